// ===== hw/rtl/stereo_chorus_modulated_delay_assert.svh =====
// Assertion macros shared by the chorus RTL.
`ifndef STEREO_CHORUS_MODULATED_DELAY_ASSERT_SVH
`define STEREO_CHORUS_MODULATED_DELAY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCMD_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chorus assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCMD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chorus assertion failed");

`endif

// ===== hw/rtl/scmd_pkg.sv =====
package scmd_pkg;

    localparam int SCMD_DIGIT = 2;

    localparam int DELAY_DEPTH  = 1024;
    localparam int SINE_ENTRIES = 256;

    localparam int STEP_NW = 56;
    localparam int STEP_DW = 38;
    localparam int STEP_QW = 32;
    localparam int DQ_NW   = 40;
    localparam int DQ_DW   = 20;
    localparam int DQ_QW   = 18;

    localparam logic [1:0] CFG_BYPASS = 2'd0;
    localparam logic [1:0] CFG_RATE   = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156};

    typedef enum logic [10:0] {
        S_CALC = 11'b000_0000_0001,
        S_DIVW = 11'b000_0000_0010,
        S_IDLE = 11'b000_0000_0100,
        S_LFO  = 11'b000_0000_1000,
        S_MUL1 = 11'b000_0001_0000,
        S_WR   = 11'b000_0010_0000,
        S_RD1  = 11'b000_0100_0000,
        S_RD2  = 11'b000_1000_0000,
        S_RDW  = 11'b001_0000_0000,
        S_MUL2 = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    // Quarter-wave sine entry in Q1.15 from a Q30 Taylor series.
    function automatic logic [15:0] sine_entry(input longint unsigned k,
                                               input int unsigned sb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          r;
        x    = (HALF_PI_Q30 * k + (64'd1 << (sb - 1))) >> sb;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        r = (acc + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        return r[15:0];
    endfunction

endpackage

// ===== hw/rtl/scmd_if.sv =====
interface scmd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scmd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface scmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/scmd_ram.sv =====
module scmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/scmd_div.sv =====
module scmd_div #(
    parameter int NW = 56,
    parameter int DW = 38,
    parameter int QW = 32,
    parameter logic [DW-1:0] DIVISOR = 38'd1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    output logic          o_busy,
    output logic [QW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [DW:0]   w_sh;
    logic          w_ge;

    always_comb begin
        w_sh   = {r_rem, r_num[NW-1]};
        w_ge   = w_sh >= {1'b0, DIVISOR};
        n_num  = r_num;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_quo  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num  = {r_num[NW-2:0], 1'b0};
            n_rem  = w_ge ? DW'(w_sh - {1'b0, DIVISOR}) : w_sh[DW-1:0];
            n_quo  = {r_quo[QW-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            n_busy = r_cnt != CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/scmd_mul.sv =====
module scmd_mul #(
    parameter int WA = 17,
    parameter int WB = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [WA-1:0]    i_a,
    input  logic [WB-1:0]           i_b,
    output logic                    o_busy,
    output logic signed [WA+WB-1:0] o_p
);

    import scmd_pkg::*;

    localparam int WP  = WA + WB;
    localparam int NS  = (WB + SCMD_DIGIT - 1) / SCMD_DIGIT;
    localparam int WBP = NS * SCMD_DIGIT;
    localparam int CW  = $clog2(NS + 1);

    logic signed [WP-1:0]         r_a, n_a;
    logic signed [WP-1:0]         r_acc, n_acc;
    logic [WBP-1:0]               r_b, n_b;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic signed [WP+SCMD_DIGIT:0] w_term;

    always_comb begin
        w_term = r_a * $signed({1'b0, r_b[SCMD_DIGIT-1:0]});
        n_a    = r_a;
        n_acc  = r_acc;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_a    = WP'(i_a);
            n_acc  = '0;
            n_b    = WBP'(i_b);
            n_cnt  = CW'(NS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc  = r_acc + w_term[WP-1:0];
            n_a    = r_a <<< SCMD_DIGIT;
            n_b    = r_b >> SCMD_DIGIT;
            n_cnt  = r_cnt - 1'b1;
            n_busy = r_cnt != CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_acc <= n_acc;
        r_b   <= n_b;
    end

    assign o_busy = r_busy;
    assign o_p    = r_acc;

endmodule

// ===== hw/rtl/stereo_chorus_modulated_delay.sv =====
// Stereo chorus on Q1.15 sample pairs.
// Input channel i_in carries one stereo word (left_in, right_in); output channel o_out
// returns one word (left_out, right_out) for each input word, in order.
// Configuration channel i_cfg writes bypass (index 0), rate (1) and depth (2); it is
// ready only while no word is being processed. After reset, and after every
// configuration write, two bit-serial dividers recompute the LFO phase step and the
// depth; no input word is taken until both have finished.
// A processed word passes the LFO, MUL1, WR, RD1, RD2, RDW, MUL2 and DONE states
// before it reaches the output register: the LFO times depth product is formed two
// bits per cycle, the delay memory has one port used for one write and two reads, and
// the interpolation products are formed the same way. A bypassed word goes via DONE
// alone; a word is taken only once the one before has reached the output register.
// The next input word is taken while a result waits in the output register; a
// word whose result is ready but blocked by a stalled receiver waits in place.
// Reset clears the LFO phase and write index and marks the delay line empty;
// unwritten delay entries read as zero.
`include "stereo_chorus_modulated_delay_assert.svh"

module stereo_chorus_modulated_delay #(
    parameter int SAMPLE_RATE  = 48000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scmd_in_if.sink     i_in,
    scmd_out_if.source  o_out,
    scmd_cfg_if.sink    i_cfg
);

    import scmd_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int PW = AW + 8;
    localparam int SB = $clog2(SINE_ENTRIES);
    localparam logic [STEP_DW-1:0] STEP_DIV =
        STEP_DW'(longint'(1024000) * longint'(SAMPLE_RATE));
    localparam logic [STEP_NW-1:0] STEP_BIAS =
        STEP_NW'(longint'(512000) * longint'(SAMPLE_RATE));
    localparam logic [DQ_DW-1:0] DQ_DIV  = DQ_DW'(1024000);
    localparam logic [DQ_NW-1:0] DQ_BIAS = DQ_NW'(512000);
    localparam logic [PW-1:0]    CENTER_Q8 = PW'(5120);

    logic [15:0] w_sine [SINE_ENTRIES+1];

    for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_sine
        assign w_sine[k] = sine_entry(longint'(k), SB);
    end

    t_state               r_state, n_state;
    logic                 r_bypass;
    logic [10:0]          r_rate;
    logic [10:0]          r_depth;
    logic [31:0]          r_phase;
    logic [AW-1:0]        r_wi;
    logic [AW:0]          r_fill;
    logic signed [15:0]   r_left, r_right;
    logic                 r_byp;
    logic [PW-1:0]        r_pos;
    logic                 r_v1, r_v2;
    logic [31:0]          r_s1;
    logic                 r_out_valid;
    logic signed [15:0]   r_out_l, r_out_r;

    logic                 w_cfg_wr, w_in_acc, w_load;
    logic [10:0]          w_rate_k, w_depth_k;
    logic [21:0]          w_rate_lin;
    logic [12:0]          w_dlin;
    logic [STEP_NW-1:0]   w_step_num;
    logic [DQ_NW-1:0]     w_dq_num;
    logic                 w_div_start, w_step_busy, w_dq_busy;
    logic [STEP_QW-1:0]   w_step;
    logic [DQ_QW-1:0]     w_depth_q8;
    logic [30:0]          w_pp;
    logic [SB:0]          w_idx;
    logic [16:0]          w_lfo_off;
    logic                 w_mul1_start, w_mul1_busy;
    logic signed [35:0]   w_p1;
    logic [PW-1:0]        w_dq, w_pos;
    logic [AW-1:0]        w_i1, w_i2, w_addr;
    logic                 w_we;
    logic [31:0]          w_rdata, w_s2;
    logic signed [16:0]   w_diff_l, w_diff_r;
    logic                 w_mul2_start, w_mul2_busy_l, w_mul2_busy_r;
    logic signed [24:0]   w_pl, w_pr;
    logic signed [25:0]   w_acc_l, w_acc_r;
    logic [16:0]          w_sum_l, w_sum_r;

    assign i_cfg.ready = (r_state == S_IDLE) || (r_state == S_DIVW);
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_rate_k   = (r_rate > 11'd1024) ? 11'd1024 : r_rate;
        w_depth_k  = (r_depth > 11'd1024) ? 11'd1024 : r_depth;
        w_rate_lin = 22'(w_rate_k * 22'd2900) + 22'd102400;
        w_step_num = STEP_NW'({w_rate_lin, 32'd0}) + STEP_BIAS;
        w_dlin     = 13'd1024 + 13'(w_depth_k * 13'd3);
        w_dq_num   = DQ_NW'({31'(w_dlin * 31'(SAMPLE_RATE)), 8'd0}) + DQ_BIAS;
    end

    assign w_div_start = r_state == S_CALC;

    scmd_div #(.NW(STEP_NW), .DW(STEP_DW), .QW(STEP_QW), .DIVISOR(STEP_DIV)) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_step_num),
        .o_busy  (w_step_busy),
        .o_quo   (w_step)
    );

    scmd_div #(.NW(DQ_NW), .DW(DQ_DW), .QW(DQ_QW), .DIVISOR(DQ_DIV)) u_div_depth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dq_num),
        .o_busy  (w_dq_busy),
        .o_quo   (w_depth_q8)
    );

    always_comb begin
        w_pp      = r_phase[30] ? (31'h4000_0000 - {1'b0, r_phase[29:0]})
                                : {1'b0, r_phase[29:0]};
        w_idx     = w_pp[30 -: SB+1];
        w_lfo_off = r_phase[31] ? (17'd32768 - {1'b0, w_sine[w_idx]})
                                : (17'd32768 + {1'b0, w_sine[w_idx]});
    end

    assign w_mul1_start = r_state == S_LFO;

    scmd_mul #(.WA(19), .WB(17)) u_mul_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul1_start),
        .i_a     ($signed({1'b0, w_depth_q8})),
        .i_b     (w_lfo_off),
        .o_busy  (w_mul1_busy),
        .o_p     (w_p1)
    );

    always_comb begin
        w_dq  = CENTER_Q8 + PW'(w_p1[35:15]);
        w_pos = {r_wi, 8'd0} - w_dq;
        w_i1  = r_pos[PW-1:8];
        w_i2  = w_i1 + 1'b1;
        w_we  = r_state == S_WR;
        if (r_state == S_WR) begin
            w_addr = r_wi;
        end else if (r_state == S_RD2) begin
            w_addr = w_i2;
        end else begin
            w_addr = w_i1;
        end
    end

    scmd_ram #(.WIDTH(32), .DEPTH(DELAY_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata ({r_right, r_left}),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_s2         = r_v2 ? w_rdata : 32'd0;
        w_diff_l     = {w_s2[15], w_s2[15:0]} - {r_s1[15], r_s1[15:0]};
        w_diff_r     = {w_s2[31], w_s2[31:16]} - {r_s1[31], r_s1[31:16]};
        w_mul2_start = r_state == S_RDW;
    end

    scmd_mul #(.WA(17), .WB(8)) u_mul_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul2_start),
        .i_a     (w_diff_l),
        .i_b     (r_pos[7:0]),
        .o_busy  (w_mul2_busy_l),
        .o_p     (w_pl)
    );

    scmd_mul #(.WA(17), .WB(8)) u_mul_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul2_start),
        .i_a     (w_diff_r),
        .i_b     (r_pos[7:0]),
        .o_busy  (w_mul2_busy_r),
        .o_p     (w_pr)
    );

    always_comb begin
        w_acc_l = $signed({{2{r_s1[15]}}, r_s1[15:0], 8'd0}) + {w_pl[24], w_pl};
        w_acc_r = $signed({{2{r_s1[31]}}, r_s1[31:16], 8'd0}) + {w_pr[24], w_pr};
        w_sum_l = {r_left[15], r_left} + w_acc_l[24:8];
        w_sum_r = {r_right[15], r_right} + w_acc_r[24:8];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CALC: n_state = S_DIVW;
            S_DIVW: begin
                if (w_cfg_wr) begin
                    n_state = S_CALC;
                end else if (!w_step_busy && !w_dq_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_cfg_wr) begin
                    n_state = S_CALC;
                end else if (w_in_acc) begin
                    n_state = r_bypass ? S_DONE : S_LFO;
                end
            end
            S_LFO:  n_state = S_MUL1;
            S_MUL1: n_state = w_mul1_busy ? S_MUL1 : S_WR;
            S_WR:   n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RDW;
            S_RDW:  n_state = S_MUL2;
            S_MUL2: n_state = (w_mul2_busy_l || w_mul2_busy_r) ? S_MUL2 : S_DONE;
            S_DONE: n_state = w_load ? S_IDLE : S_DONE;
            default: n_state = S_CALC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CALC;
            r_bypass    <= 1'b0;
            r_rate      <= 11'd512;
            r_depth     <= 11'd512;
            r_phase     <= '0;
            r_wi        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (i_cfg.index)
                    CFG_BYPASS: r_bypass <= i_cfg.data[0];
                    CFG_RATE:   r_rate   <= i_cfg.data;
                    CFG_DEPTH:  r_depth  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == S_LFO) begin
                r_phase <= r_phase + w_step;
            end
            if (r_state == S_WR) begin
                r_wi <= r_wi + 1'b1;
                if (r_fill != (AW+1)'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_left  <= i_in.left_in;
            r_right <= i_in.right_in;
            r_byp   <= r_bypass;
        end
        if (r_state == S_WR) begin
            r_pos <= w_pos;
        end
        if (r_state == S_RD1) begin
            r_v1 <= {1'b0, w_i1} < r_fill;
        end
        if (r_state == S_RD2) begin
            r_s1 <= r_v1 ? w_rdata : 32'd0;
            r_v2 <= {1'b0, w_i2} < r_fill;
        end
        if (w_load) begin
            r_out_l <= r_byp ? r_left : $signed(w_sum_l[16:1]);
            r_out_r <= r_byp ? r_right : $signed(w_sum_r[16:1]);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    `SCMD_ASSERT_NEXT(a_leave_idle, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)
    `SCMD_ASSERT_SAME(a_mul_in_state, i_clk, i_rst_n, w_mul1_busy, r_state == S_MUL1)
    `SCMD_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= (AW+1)'(DELAY_DEPTH))
    `SCMD_ASSERT_SAME(a_div_idle, i_clk, i_rst_n, w_step_busy, (r_state == S_CALC) || (r_state == S_DIVW))

endmodule

// ===== bench/stereo_chorus_modulated_delay_tb.sv =====
module stereo_chorus_modulated_delay_tb;
    import scmd_pkg::*;

    localparam int RING_WORDS  = 1024;
    localparam int RATE_HZ     = 48000;
    localparam int QUARTER     = 256;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } frame_t;

    class chorus_scoreboard;
        logic               bypass;
        int unsigned        rate_knob;
        int unsigned        depth_knob;
        logic [31:0]        lfo_phase;
        logic [31:0]        ring [RING_WORDS];
        int unsigned        wr_idx;
        int                 quarter_sine [QUARTER + 1];
        frame_t             pending [$];
        int                 errors;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            longint          r;
            for (int k = 0; k <= QUARTER; k++) begin
                x    = (64'd1686629713 * k + QUARTER / 2) / QUARTER;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int n = 1; n <= 6; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
                end
                if (acc < 0) acc = 0;
                r = (acc + 16384) >>> 15;
                quarter_sine[k] = (r > 32767) ? 32767 : int'(r);
            end
            for (int k = 0; k < RING_WORDS; k++) ring[k] = '0;
            wr_idx     = 0;
            lfo_phase  = '0;
            bypass     = 1'b0;
            rate_knob  = 512;
            depth_knob = 512;
            errors     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [10:0] value);
            case (idx)
                CFG_BYPASS: bypass = value[0];
                CFG_RATE: rate_knob = value;
                CFG_DEPTH: depth_knob = value;
                default: ;
            endcase
        endfunction

        function int lfo_sample(logic [31:0] ph);
            longint unsigned p;
            longint unsigned idx;
            int              v;
            p = ph[29:0];
            if (ph[30]) p = 64'h4000_0000 - p;
            idx = (p * QUARTER) >> 30;
            if (idx > QUARTER) idx = QUARTER;
            v = quarter_sine[idx];
            return ph[31] ? -v : v;
        endfunction

        function int tap(longint unsigned pos, int sh);
            int unsigned     i1;
            int unsigned     i2;
            longint          f;
            longint          s1;
            longint          s2;
            longint          acc;
            logic [31:0]     w1;
            logic [31:0]     w2;
            i1  = (pos >> 8) % RING_WORDS;
            i2  = (i1 + 1) % RING_WORDS;
            f   = pos & 8'hFF;
            w1  = ring[i1];
            w2  = ring[i2];
            s1  = (sh == 0) ? longint'($signed(w1[15:0])) : longint'($signed(w1[31:16]));
            s2  = (sh == 0) ? longint'($signed(w2[15:0])) : longint'($signed(w2[31:16]));
            acc = s1 * 256 + f * (s2 - s1) + 32768 * 256;
            return int'(acc / 256) - 32768;
        endfunction

        function void note_input(logic signed [15:0] l, logic signed [15:0] r);
            frame_t          e;
            longint unsigned rk;
            longint unsigned dk;
            longint unsigned stp;
            longint unsigned dep;
            longint unsigned total;
            longint unsigned dq;
            longint unsigned pos;
            longint          md;
            int              lfo;
            int              dry [2];
            int              wet;
            int              res [2];
            dry[0] = l;
            dry[1] = r;
            if (bypass) begin
                e.left  = l;
                e.right = r;
                pending.push_back(e);
                return;
            end
            rk    = (rate_knob > 1024) ? 1024 : rate_knob;
            dk    = (depth_knob > 1024) ? 1024 : depth_knob;
            stp   = (((64'd102400 + rk * 2900) << 32) + 64'd512000 * RATE_HZ)
                    / (64'd1024000 * RATE_HZ);
            dep   = ((64'd1024 + 3 * dk) * RATE_HZ * 256 + 64'd512000) / 64'd1024000;
            lfo   = lfo_sample(lfo_phase);
            lfo_phase = lfo_phase + stp[31:0];
            md    = ((longint'(lfo) + 32768) * longint'(dep)) / 32768 - longint'(dep);
            total = RING_WORDS * 256;
            dq    = longint'(longint'(dep) + 20 * 256 + md) % total;
            ring[wr_idx] = {r, l};
            pos   = (longint'(wr_idx) * 256 + total - dq) % total;
            for (int ch = 0; ch < 2; ch++) begin
                wet     = tap(pos, ch);
                res[ch] = (dry[ch] + wet + 65536) / 2 - 32768;
            end
            e.left  = res[0][15:0];
            e.right = res[1][15:0];
            pending.push_back(e);
            wr_idx = (wr_idx + 1) % RING_WORDS;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check(logic signed [15:0] l, logic signed [15:0] r);
            frame_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word left=%0d right=%0d", l, r));
                return;
            end
            e = pending.pop_front();
            if (l !== e.left)
                report($sformatf("left_out got %0d expected %0d", l, e.left));
            if (r !== e.right)
                report($sformatf("right_out got %0d expected %0d", r, e.right));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    bit   idling = 1'b1;
    bit   hold_req = 1'b0;
    chorus_scoreboard board;

    scmd_in_if  in_ch();
    scmd_out_if out_ch();
    scmd_cfg_if cfg_ch();

    stereo_chorus_modulated_delay uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_input(in_ch.left_in, in_ch.right_in);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check(out_ch.left_out, out_ch.right_out);
    end

    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (i_rst_n && idling && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task send_word(logic signed [15:0] l, logic signed [15:0] r);
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (idling && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [10:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.set_register(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task run_phase(logic byp, logic [10:0] rate, logic [10:0] depth, int count);
        drain();
        write_reg(CFG_BYPASS, {10'd0, byp});
        write_reg(CFG_RATE, rate);
        write_reg(CFG_DEPTH, depth);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2 && idling) hold_req = 1'b1;
            send_word(pick_sample(), pick_sample());
        end
    endtask

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_BYPASS;
        cfg_ch.data    = '0;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
        send_word(16'sh0000, 16'sh0000);
        send_word(16'shFFFF, 16'sh0001);
        send_word(16'sh5555, 16'shAAAA);
        send_word(16'shAAAA, 16'sh5555);
        for (int n = 0; n < 6; n++) send_word(16'sh7FFF, 16'sh8000);
        drain();
        write_reg(CFG_BYPASS, 11'd1);
        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
        send_word(16'sh1234, 16'shEDCB);
        drain();
        write_reg(CFG_BYPASS, 11'd0);
        write_reg(CFG_RATE, 11'd2047);
        write_reg(CFG_DEPTH, 11'd2047);
        for (int n = 0; n < 6; n++) send_word(16'sh8000, 16'sh7FFF);

        hold_req = 1'b1;
        run_phase(1'b0, 11'd0, 11'd0, 150);
        run_phase(1'b0, 11'd1024, 11'd1024, 150);
        run_phase(1'b1, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), 100);
        run_phase(1'b0, 11'd2047, 11'd2047, 150);
        run_phase(1'b0, 11'd1025, 11'd0, 150);
        run_phase(1'b0, 11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024)), 150);
        drain();
        idling = 1'b0;
        run_phase(1'b0, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), 150);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
